FILE: rtl/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
package bdq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REM_FRONT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REM_BACK  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // update positions, count and ring entry
    logic rd;     // read front and back entries
  } cmd_t;

endpackage

FILE: rtl/bdq_ctrl.sv
// Request sequencer: accept, execute, read, present.
module bdq_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bdq_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_HOLD
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q <= S_READ;
        end
        S_READ: begin
          state_q     <= S_HOLD;
          out_valid_q <= 1'b1;
        end
        S_HOLD: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = in_valid_i && in_ready_q;
    cmd_o.exec = (state_q == S_EXEC);
    cmd_o.rd   = (state_q == S_READ);
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_q && out_valid_q))
    else $error("input and output sides open together");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec)
    else $error("accepted item not executed next cycle");

  a_read_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> out_valid_q)
    else $error("read not followed by a result");

endmodule

FILE: rtl/bdq_dpath.sv
// Ring store, positions, count and result registers.
module bdq_dpath #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bdq_pkg::cmd_t                  cmd_i,
  input  logic [bdq_pkg::KIND_W-1:0]     kind_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] item_value_i,
  output logic [bdq_pkg::STATUS_W-1:0]   status_o,
  output logic [bdq_pkg::COUNT_W-1:0]    entry_count_o,
  output logic signed [bdq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [bdq_pkg::DATA_W-1:0] back_value_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];

  logic [bdq_pkg::KIND_W-1:0]   kind_q;
  logic [bdq_pkg::DATA_W-1:0]   value_q;
  logic [PTR_W-1:0]             front_q, front_d;
  logic [PTR_W-1:0]             back_q, back_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [bdq_pkg::STATUS_W-1:0] status_q, status_d;
  logic                         wr_en;
  logic [PTR_W-1:0]             wr_addr;
  logic [bdq_pkg::DATA_W-1:0]   rd_front_q, rd_back_q;

  function automatic logic [PTR_W-1:0] pos_next(input logic [PTR_W-1:0] p);
    pos_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] pos_prev(input logic [PTR_W-1:0] p);
    pos_prev = (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    status_d = bdq_pkg::STATUS_DONE;
    wr_en    = 1'b0;
    wr_addr  = front_q;
    case (kind_q)
      bdq_pkg::KIND_INS_BACK, bdq_pkg::KIND_INS_FRONT: begin
        if (count_q == CNT_FULL) begin
          status_d = bdq_pkg::STATUS_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (count_q == '0) begin
            back_d  = front_q;
            wr_addr = front_q;
          end else if (kind_q == bdq_pkg::KIND_INS_BACK) begin
            back_d  = pos_next(back_q);
            wr_addr = back_d;
          end else begin
            front_d = pos_prev(front_q);
            wr_addr = front_d;
          end
        end
      end
      bdq_pkg::KIND_REM_FRONT, bdq_pkg::KIND_REM_BACK: begin
        if (count_q == '0) begin
          status_d = bdq_pkg::STATUS_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
          // last entry leaves: positions stay equal
          if (count_d != '0) begin
            if (kind_q == bdq_pkg::KIND_REM_FRONT) front_d = pos_next(front_q);
            else                                   back_d  = pos_prev(back_q);
          end
        end
      end
      default: begin
        status_d = bdq_pkg::STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      back_q   <= '0;
      count_q  <= '0;
      status_q <= bdq_pkg::STATUS_DONE;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= item_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_front_q <= mem[front_q];
      rd_back_q  <= mem[back_q];
    end
  end

  assign status_o      = status_q;
  assign entry_count_o = bdq_pkg::COUNT_W'(count_q);
  assign front_value_o = (count_q == '0) ? '0 : $signed(rd_front_q);
  assign back_value_o  = (count_q == '0) ? '0 : $signed(rd_back_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("count beyond depth");

  a_single_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= 1) |-> (front_q == back_q))
    else $error("front and back differ with at most one entry");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && status_d == bdq_pkg::STATUS_FULL) |=> (count_q == CNT_FULL))
    else $error("full status on a queue that is not full");

endmodule

FILE: rtl/bounded_double_ended_queue_unit.sv
// Top level of the bounded double-ended queue: controller plus datapath.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o   kind_i, item_value_i
//   out      output     out_valid_o / out_ready_i status_o, entry_count_o,
//                                                 front_value_o, back_value_o
//
// Each item passes through accept, execute (positions, count, ring write),
// read of the front and back entries through the registered read ports, result.
// A new item is taken only after the previous result has been taken.
// Reset clears positions and count; ring entries are left as they are.
// A stall on the output holds the result and keeps the input closed.
module bounded_double_ended_queue_unit #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bdq_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bdq_pkg::STATUS_W-1:0]      status_o,
  output logic [bdq_pkg::COUNT_W-1:0]       entry_count_o,
  output logic signed [bdq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [bdq_pkg::DATA_W-1:0] back_value_o
);

  bdq_pkg::cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .item_value_i  (item_value_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o)
  );

endmodule

FILE: tb/bounded_double_ended_queue_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded double-ended queue unit.
module bounded_double_ended_queue_unit_test;

  localparam int unsigned DEPTH       = bdq_pkg::DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic [bdq_pkg::STATUS_W-1:0]      status;
    logic [bdq_pkg::COUNT_W-1:0]       count;
    logic signed [bdq_pkg::DATA_W-1:0] front;
    logic signed [bdq_pkg::DATA_W-1:0] back;
  } deque_result_t;

  logic                              clk_i        = 1'b0;
  logic                              rst_ni       = 1'b0;
  logic                              in_valid_i   = 1'b0;
  logic                              in_ready_o;
  logic [bdq_pkg::KIND_W-1:0]        kind_i       = bdq_pkg::KIND_INS_BACK;
  logic signed [bdq_pkg::DATA_W-1:0] item_value_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i  = 1'b0;
  logic [bdq_pkg::STATUS_W-1:0]      status_o;
  logic [bdq_pkg::COUNT_W-1:0]       entry_count_o;
  logic signed [bdq_pkg::DATA_W-1:0] front_value_o;
  logic signed [bdq_pkg::DATA_W-1:0] back_value_o;

  // predictor state: ring contents, end positions and fill level
  logic signed [bdq_pkg::DATA_W-1:0] ring [DEPTH];
  int unsigned                head_pos = 0;
  int unsigned                tail_pos = 0;
  int unsigned                held     = 0;

  deque_result_t              pending_results [$];
  int unsigned                mismatches  = 0;
  int unsigned                cycle_count = 0;
  bit                         idle_off    = 1'b0;

  bounded_double_ended_queue_unit #(.DEPTH(DEPTH)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("bounded_double_ended_queue_unit_test failed");
      $finish;
    end
  end

  // applies one request to the predictor and returns the result it should give
  function automatic deque_result_t deque_apply(
    input logic [bdq_pkg::KIND_W-1:0]        kind,
    input logic signed [bdq_pkg::DATA_W-1:0] value
  );
    deque_result_t res;
    res.status = bdq_pkg::STATUS_DONE;
    if (kind == bdq_pkg::KIND_INS_BACK || kind == bdq_pkg::KIND_INS_FRONT) begin
      if (held >= DEPTH) begin
        res.status = bdq_pkg::STATUS_FULL;
      end else begin
        // an empty queue inserts at the front position either way
        if (held == 0)
          tail_pos = head_pos;
        else if (kind == bdq_pkg::KIND_INS_BACK)
          tail_pos = (tail_pos + 1) % DEPTH;
        else
          head_pos = (head_pos + DEPTH - 1) % DEPTH;
        if (kind == bdq_pkg::KIND_INS_BACK)
          ring[tail_pos] = value;
        else
          ring[head_pos] = value;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = bdq_pkg::STATUS_EMPTY;
      end else begin
        held--;
        if (held > 0) begin
          if (kind == bdq_pkg::KIND_REM_FRONT)
            head_pos = (head_pos + 1) % DEPTH;
          else
            tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
        end
      end
    end
    res.count = bdq_pkg::COUNT_W'(held);
    res.front = (held > 0) ? ring[head_pos] : '0;
    res.back  = (held > 0) ? ring[tail_pos] : '0;
    return res;
  endfunction

  function automatic logic signed [bdq_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(11))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [bdq_pkg::DATA_W-1:0] got,
                                 input logic [bdq_pkg::DATA_W-1:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0d: mismatch on %s: got %0h, expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // drives one item and waits for it to be taken; optional idle gap in front
  task automatic send_request(input logic [bdq_pkg::KIND_W-1:0] kind,
                              input logic signed [bdq_pkg::DATA_W-1:0] value);
    int unsigned gap;
    if (!idle_off && $urandom_range(99) < 8) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    item_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(deque_apply(kind, value));
  endtask

  // result checker and output-side back-pressure
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, status_o}, '0);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", {30'd0, status_o}, {30'd0, want.status});
          if (entry_count_o !== want.count)
            report_mismatch("entry_count", {27'd0, entry_count_o}, {27'd0, want.count});
          if (front_value_o !== want.front)
            report_mismatch("front_value", front_value_o, want.front);
          if (back_value_o !== want.back)
            report_mismatch("back_value", back_value_o, want.back);
        end
      end
      out_ready_i <= idle_off || ($urandom_range(99) >= 8);
    end
  end

  task automatic test_directed();
    send_request(bdq_pkg::KIND_REM_FRONT, 32'sd5);            // remove from empty
    send_request(bdq_pkg::KIND_REM_BACK, -32'sd5);            // remove from empty
    send_request(bdq_pkg::KIND_INS_BACK, 32'sh7fff_ffff);
    send_request(bdq_pkg::KIND_INS_FRONT, 32'sh8000_0000);
    send_request(bdq_pkg::KIND_REM_FRONT, '0);
    send_request(bdq_pkg::KIND_REM_BACK, '0);                 // back to empty
    send_request(bdq_pkg::KIND_INS_FRONT, -32'sd1);           // first insert at front
    send_request(bdq_pkg::KIND_INS_FRONT, 32'sh5555_5555);    // front wraps below zero
    send_request(bdq_pkg::KIND_INS_BACK, '0);
    send_request(bdq_pkg::KIND_INS_BACK, 32'shaaaa_aaaa);
    send_request(bdq_pkg::KIND_REM_BACK, '0);
    send_request(bdq_pkg::KIND_REM_FRONT, '0);
    send_request(bdq_pkg::KIND_REM_FRONT, '0);
    send_request(bdq_pkg::KIND_REM_BACK, '0);
    send_request(bdq_pkg::KIND_REM_BACK, '0);                 // remove from empty again
    send_request(bdq_pkg::KIND_INS_BACK, -32'sd2);            // single entry is both ends
    send_request(bdq_pkg::KIND_REM_FRONT, '0);
  endtask

  // fill to the bound, overfill, drain and over-drain with random sides
  task automatic test_fill_drain();
    for (int round = 0; round < 3; round++) begin
      for (int i = 0; i < DEPTH + 2; i++)
        send_request($urandom_range(1) ? bdq_pkg::KIND_INS_BACK : bdq_pkg::KIND_INS_FRONT,
                     random_value());
      for (int i = 0; i < DEPTH + 2; i++)
        send_request($urandom_range(1) ? bdq_pkg::KIND_REM_FRONT : bdq_pkg::KIND_REM_BACK,
                     random_value());
    end
  endtask

  // biased walk over the fill level so it swings between empty and full
  task automatic run_walk(input int unsigned n_items);
    int unsigned insert_pct;
    logic [bdq_pkg::KIND_W-1:0] kind;
    insert_pct = 70;
    for (int i = 0; i < n_items; i++) begin
      if (held == DEPTH)
        insert_pct = $urandom_range(15, 40);
      else if (held == 0)
        insert_pct = $urandom_range(60, 85);
      else if ($urandom_range(29) == 0)
        insert_pct = $urandom_range(20, 80);
      if ($urandom_range(99) < insert_pct)
        kind = $urandom_range(1) ? bdq_pkg::KIND_INS_BACK : bdq_pkg::KIND_INS_FRONT;
      else
        kind = $urandom_range(1) ? bdq_pkg::KIND_REM_FRONT : bdq_pkg::KIND_REM_BACK;
      send_request(kind, random_value());
    end
  endtask

  task automatic test_random_walk();
    run_walk(450);
  endtask

  task automatic test_back_to_back();
    idle_off = 1'b1;
    run_walk(150);
    idle_off = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_drain();
    test_random_walk();
    test_back_to_back();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("bounded_double_ended_queue_unit_test passed");
    else
      $display("bounded_double_ended_queue_unit_test failed");
    $finish;
  end

endmodule
